[rtl/core/hta_pkg.sv]
// shared constants for the heron triangle area block
package hta_pkg;

  // default side width, fixed widths of the port fields
  localparam int SIDE_BITS_DEF = 12;
  localparam int SIDE_W        = 12;
  localparam int AREA_W        = 31;

  // radicand shift: 16*area^2 scaled to an 8-bit fractional root
  localparam int FRAC_SHIFT = 12;

  // stream payload widths, tdata padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 1;

endpackage

[rtl/core/hta_front.sv]
// front end: triangle check, the four factors and their product
module hta_front #(
  parameter int SIDE_BITS = hta_pkg::SIDE_BITS_DEF,
  parameter int RAD_W     = 4 * SIDE_BITS + 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [hta_pkg::SIDE_W-1:0] side_a,
  input  logic [hta_pkg::SIDE_W-1:0] side_b,
  input  logic [hta_pkg::SIDE_W-1:0] side_c,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [RAD_W-1:0]          out_rad,
  output logic                      out_ok
);
  import hta_pkg::*;

  localparam int SUM_W = SIDE_BITS + 2;
  localparam int DIF_W = SIDE_BITS + 1;
  localparam int M1_W  = SUM_W + DIF_W;
  localparam int M2_W  = 2 * DIF_W;
  localparam int LO_W  = DIF_W;
  localparam int PP_W  = M1_W + LO_W;
  localparam int PW    = 4 * SIDE_BITS + 2;
  localparam int ACC_W = M1_W + M2_W;

  // stage valids and ready chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy;

  assign s4_rdy   = !s4_v_r || out_ready;
  assign s3_rdy   = !s3_v_r || s4_rdy;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // masked sides and the strict triangle inequality
  logic [SUM_W-1:0] a_m, b_m, c_m;
  logic [SUM_W-1:0] ab, bc, ac, abc;
  logic             ok_c;
  logic [SUM_W-1:0] x_c, y_c, z_c;

  always_comb begin
    a_m  = SUM_W'(side_a[SIDE_BITS-1:0]);
    b_m  = SUM_W'(side_b[SIDE_BITS-1:0]);
    c_m  = SUM_W'(side_c[SIDE_BITS-1:0]);
    ab   = a_m + b_m;
    bc   = b_m + c_m;
    ac   = a_m + c_m;
    abc  = ab + c_m;
    ok_c = (ab > c_m) && (bc > a_m) && (ac > b_m);
    x_c  = bc - a_m;
    y_c  = ac - b_m;
    z_c  = ab - c_m;
  end

  // stage 1: sum and differences, zeroed when not a triangle
  logic [SUM_W-1:0] s1_sum_r;
  logic [DIF_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic             s1_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_r <= in_valid;
    end
    if (s1_rdy) begin
      s1_ok_r  <= ok_c;
      s1_sum_r <= ok_c ? abc : '0;
      s1_x_r   <= ok_c ? x_c[DIF_W-1:0] : '0;
      s1_y_r   <= ok_c ? y_c[DIF_W-1:0] : '0;
      s1_z_r   <= ok_c ? z_c[DIF_W-1:0] : '0;
    end
  end

  // stage 2: two pairwise products
  logic [M1_W-1:0] s2_m1_r;
  logic [M2_W-1:0] s2_m2_r;
  logic            s2_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_rdy) begin
      s2_ok_r <= s1_ok_r;
      s2_m1_r <= M1_W'(s1_sum_r) * M1_W'(s1_x_r);
      s2_m2_r <= M2_W'(s1_y_r) * M2_W'(s1_z_r);
    end
  end

  // stage 3: partial products of the wide multiply, split on m2
  logic [PP_W-1:0] s3_pp_lo_r, s3_pp_hi_r;
  logic            s3_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_r <= s2_v_r;
    end
    if (s3_rdy) begin
      s3_ok_r    <= s2_ok_r;
      s3_pp_lo_r <= PP_W'(s2_m1_r) * PP_W'(s2_m2_r[LO_W-1:0]);
      s3_pp_hi_r <= PP_W'(s2_m1_r) * PP_W'(s2_m2_r[M2_W-1:LO_W]);
    end
  end

  // stage 4: combine partials, append the fractional scaling
  logic [ACC_W-1:0] prod_c;

  assign prod_c = ACC_W'(s3_pp_lo_r) + (ACC_W'(s3_pp_hi_r) << LO_W);

  logic [RAD_W-1:0] s4_rad_r;
  logic             s4_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_v_r <= s3_v_r;
    end
    if (s4_rdy) begin
      s4_ok_r  <= s3_ok_r;
      s4_rad_r <= {prod_c[PW-1:0], {FRAC_SHIFT{1'b0}}};
    end
  end

  assign out_valid = s4_v_r;
  assign out_rad   = s4_rad_r;
  assign out_ok    = s4_ok_r;

endmodule

[rtl/core/hta_sqrt_cell.sv]
// one cell of the square root chain: resolves one root bit per item
module hta_sqrt_cell #(
  parameter int RAD_W = 62,
  parameter int RT_W  = 31
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [RT_W:0]     in_rem,
  input  logic [RT_W-1:0]   in_root,
  input  logic              in_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RAD_W-1:0]  out_rad,
  output logic [RT_W:0]     out_rem,
  output logic [RT_W-1:0]   out_root,
  output logic              out_ok
);
  import hta_pkg::*;

  localparam int CUR_W = RT_W + 3;

  logic             v_r;
  logic [RAD_W-1:0] rad_r;
  logic [RT_W:0]    rem_r;
  logic [RT_W-1:0]  root_r;
  logic             ok_r;

  assign in_ready = !v_r || out_ready;

  // trial subtract of the next digit pair
  logic [CUR_W-1:0] cur, trial, diff;
  logic             ge;
  logic [RT_W:0]    rem_nxt;
  logic [RT_W-1:0]  root_nxt;
  logic [RAD_W-1:0] rad_nxt;

  always_comb begin
    cur      = {in_rem, in_rad[RAD_W-1 -: 2]};
    trial    = CUR_W'({in_root, 2'b01});
    ge       = cur >= trial;
    diff     = cur - trial;
    rem_nxt  = ge ? diff[RT_W:0] : cur[RT_W:0];
    root_nxt = {in_root[RT_W-2:0], ge};
    rad_nxt  = {in_rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      ok_r   <= in_ok;
    end
  end

  assign out_valid = v_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_ok    = ok_r;

endmodule

[rtl/core/heron_triangle_area.sv]
// top level: triangle area by heron's formula, front end plus root chain
// throughput: one item per cycle while the output is not stalled, set by one root bit resolved per chain cell
// every stage holds only while its downstream neighbor is full and stalled
// reset: synchronous active-low rst_n clears all stage valid flags
// no clearing pass; the block accepts items from the first cycle after reset
module heron_triangle_area #(
  parameter int SIDE_BITS = hta_pkg::SIDE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // fields from bit 0: side_first[11:0], side_second[23:12], side_third[35:24], zero pad
  input  logic [hta_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fields from bit 0: area_fixed[30:0], zero pad
  output logic [hta_pkg::OUT_TDATA_W-1:0] out_tdata,
  // fields from bit 0: forms_triangle[0]
  output logic [hta_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import hta_pkg::*;

  localparam int RAD_W  = 4 * SIDE_BITS + 14;
  localparam int RT_W   = RAD_W / 2;
  localparam int NCELLS = RT_W;

  // chain links between front end and cells
  logic              lk_valid [0:NCELLS];
  logic              lk_ready [0:NCELLS];
  logic [RAD_W-1:0]  lk_rad   [0:NCELLS];
  logic [RT_W:0]     lk_rem   [0:NCELLS];
  logic [RT_W-1:0]   lk_root  [0:NCELLS];
  logic              lk_ok    [0:NCELLS];

  // factors and product of heron's formula
  hta_front #(
    .SIDE_BITS (SIDE_BITS),
    .RAD_W     (RAD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .side_a    (in_tdata[SIDE_W-1:0]),
    .side_b    (in_tdata[2*SIDE_W-1:SIDE_W]),
    .side_c    (in_tdata[3*SIDE_W-1:2*SIDE_W]),
    .out_valid (lk_valid[0]),
    .out_ready (lk_ready[0]),
    .out_rad   (lk_rad[0]),
    .out_ok    (lk_ok[0])
  );

  assign lk_rem[0]  = '0;
  assign lk_root[0] = '0;

  // root chain, most significant digit pair first
  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    hta_sqrt_cell #(
      .RAD_W (RAD_W),
      .RT_W  (RT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lk_valid[i]),
      .in_ready  (lk_ready[i]),
      .in_rad    (lk_rad[i]),
      .in_rem    (lk_rem[i]),
      .in_root   (lk_root[i]),
      .in_ok     (lk_ok[i]),
      .out_valid (lk_valid[i+1]),
      .out_ready (lk_ready[i+1]),
      .out_rad   (lk_rad[i+1]),
      .out_rem   (lk_rem[i+1]),
      .out_root  (lk_root[i+1]),
      .out_ok    (lk_ok[i+1])
    );
  end

  // last cell registers are the output register
  assign lk_ready[NCELLS] = out_tready;
  assign out_tvalid       = lk_valid[NCELLS];
  assign out_tdata        = OUT_TDATA_W'(AREA_W'(lk_root[NCELLS]));
  assign out_tuser        = OUT_TUSER_W'(lk_ok[NCELLS]);

endmodule

[bench/hta_checker.sv]
// scoreboard for the heron triangle area block: predicts each item's area and compares
`timescale 1ns / 100ps

module hta_checker #(
  parameter int SIDE_BITS = hta_pkg::SIDE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // fields from bit 0: side_first[11:0], side_second[23:12], side_third[35:24], zero pad
  input  logic [hta_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // fields from bit 0: area_fixed[30:0], zero pad
  input  logic [hta_pkg::OUT_TDATA_W-1:0] out_tdata,
  // fields from bit 0: forms_triangle[0]
  input  logic [hta_pkg::OUT_TUSER_W-1:0] out_tuser,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [hta_pkg::AREA_W-1:0] area_fixed;
    logic                       forms_triangle;
  } area_result_t;

  area_result_t area_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // one line per mismatch, printing capped so a broken block stays readable
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (fail_count < 40)
      $display("%0t hta_checker: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // heron area in q.8: floor(sqrt(product of the four factors << 12))
  function automatic area_result_t heron_area(input logic [hta_pkg::SIDE_W-1:0] s1,
                                              input logic [hta_pkg::SIDE_W-1:0] s2,
                                              input logic [hta_pkg::SIDE_W-1:0] s3);
    logic [63:0]  mask;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [63:0]  c;
    logic [63:0]  radicand;
    logic [63:0]  root;
    logic [63:0]  trial;
    area_result_t res;
    mask = (64'd1 << SIDE_BITS) - 64'd1;
    a    = {52'd0, s1} & mask;
    b    = {52'd0, s2} & mask;
    c    = {52'd0, s3} & mask;
    res  = '0;
    if (a + b > c && b + c > a && a + c > b) begin
      radicand = (a + b + c) * (b + c - a) * (a + c - b) * (a + b - c);
      radicand = radicand << hta_pkg::FRAC_SHIFT;
      // bitwise root search from the top bit down
      root = 64'd0;
      for (int k = hta_pkg::AREA_W - 1; k >= 0; k--) begin
        trial = root | (64'd1 << k);
        if (trial * trial <= radicand)
          root = trial;
      end
      res.area_fixed     = root[hta_pkg::AREA_W-1:0];
      res.forms_triangle = 1'b1;
    end
    return res;
  endfunction

  // watch both channels; accepted item pushes a prediction, accepted result pops one
  always @(posedge clk) begin
    area_result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready)
        area_q.push_back(heron_area(in_tdata[hta_pkg::SIDE_W-1:0],
                                    in_tdata[2*hta_pkg::SIDE_W-1:hta_pkg::SIDE_W],
                                    in_tdata[3*hta_pkg::SIDE_W-1:2*hta_pkg::SIDE_W]));
      if (out_tvalid && out_tready) begin
        if (area_q.size() == 0) begin
          report_mismatch("result with nothing pending, area", out_tdata[hta_pkg::AREA_W-1:0], 0);
        end else begin
          want = area_q.pop_front();
          if (out_tdata[hta_pkg::AREA_W-1:0] !== want.area_fixed)
            report_mismatch("area_fixed", out_tdata[hta_pkg::AREA_W-1:0], want.area_fixed);
          if (out_tuser[0] !== want.forms_triangle)
            report_mismatch("forms_triangle", out_tuser[0], want.forms_triangle);
        end
      end
    end
    pending <= area_q.size();
  end

endmodule

[bench/tb_heron_triangle_area.sv]
// stimulus and verdict for the heron triangle area block
`timescale 1ns / 100ps

module tb_heron_triangle_area;

  localparam int SW = hta_pkg::SIDE_W;

  typedef enum {SINK_OPEN, SINK_COIN, SINK_TIGHT, SINK_TOGGLE} sink_mode_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [hta_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [hta_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [hta_pkg::OUT_TUSER_W-1:0] out_tuser;
  int                              fail_count;
  int                              pending;
  int                              burst_left = 0;

  heron_triangle_area dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  hta_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("tb_heron_triangle_area: FAIL");
    $finish;
  end

  // offer one item, idling between bursts of random length
  task automatic offer(input logic [SW-1:0] a, input logic [SW-1:0] b, input logic [SW-1:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tdata  <= {{(hta_pkg::IN_TDATA_W - 3 * SW){1'b0}}, c, b, a};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering until every predicted result has come out
  task automatic drain;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // random sides: half proper triangles, the rest near-degenerate, tiny or raw
  task automatic pick_sides(output logic [SW-1:0] a, output logic [SW-1:0] b,
                            output logic [SW-1:0] c);
    int roll;
    int x;
    int y;
    int z;
    int lo;
    int hi;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      x  = $urandom_range(1, 4095);
      y  = $urandom_range(1, 4095);
      lo = ((x > y) ? x - y : y - x) + 1;
      hi = (x + y - 1 > 4095) ? 4095 : x + y - 1;
      z  = $urandom_range(hi, lo);
    end else if (roll < 65) begin
      // sum of two sides lands on or next to the third
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095 - x);
      z = x + y + 1 - $urandom_range(0, 2);
      if (z < 0) z = 0;
      if (z > 4095) z = 4095;
    end else if (roll < 80) begin
      x = $urandom_range(0, 7);
      y = $urandom_range(0, 7);
      z = $urandom_range(0, 7);
    end else begin
      x = $urandom_range(0, 4095);
      y = $urandom_range(0, 4095);
      z = $urandom_range(0, 4095);
    end
    case ($urandom_range(0, 2))
      0: begin
        a = SW'(x); b = SW'(y); c = SW'(z);
      end
      1: begin
        a = SW'(y); b = SW'(z); c = SW'(x);
      end
      default: begin
        a = SW'(z); b = SW'(x); c = SW'(y);
      end
    endcase
  endtask

  // result sink: changing stall patterns, plus one long hold to back up the pipeline
  initial begin : result_sink
    sink_mode_t mode;
    int         span;
    int         seen;
    bit         held;
    mode = SINK_OPEN;
    span = 0;
    seen = 0;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (out_tvalid && out_tready) seen++;
      if (!held && seen >= 100) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          SINK_OPEN:  out_tready <= 1'b1;
          SINK_COIN:  out_tready <= ($urandom_range(0, 1) == 1);
          SINK_TIGHT: out_tready <= ($urandom_range(0, 3) == 0);
          default:    out_tready <= ~out_tready;
        endcase
        @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    logic [SW-1:0] a;
    logic [SW-1:0] b;
    logic [SW-1:0] c;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero sides, degenerate sets, small exact triangles
    offer(12'd0, 12'd0, 12'd0);
    offer(12'd4095, 12'd4095, 12'd4095);
    offer(12'd4095, 12'd4095, 12'd1);
    offer(12'd4095, 12'd1, 12'd4095);
    offer(12'd1, 12'd4095, 12'd4095);
    offer(12'd4095, 12'd4095, 12'd0);
    offer(12'd0, 12'd5, 12'd5);
    offer(12'd5, 12'd0, 12'd5);
    offer(12'd5, 12'd5, 12'd0);
    offer(12'd1, 12'd1, 12'd1);
    offer(12'd3, 12'd4, 12'd5);
    offer(12'd1, 12'd2, 12'd3);
    offer(12'd2, 12'd3, 12'd1);
    offer(12'd3, 12'd1, 12'd2);
    offer(12'd4095, 12'd2048, 12'd2047);
    offer(12'd4095, 12'd2048, 12'd2048);
    offer(12'd4094, 12'd4095, 12'd1);
    offer(12'd100, 12'd200, 12'd50);
    offer(12'd2, 12'd2, 12'd3);
    offer(12'd2730, 12'd1365, 12'd4095);
    offer(12'd2048, 12'd2048, 12'd2048);
    drain();

    // random part, with one full pause midway
    for (int i = 0; i < 500; i++) begin
      if (i == 250) drain();
      pick_sides(a, b, c);
      offer(a, b, c);
    end

    drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_heron_triangle_area: PASS");
    else
      $display("tb_heron_triangle_area: FAIL");
    $finish;
  end

endmodule

[sim.f]
rtl/core/hta_pkg.sv
rtl/core/hta_front.sv
rtl/core/hta_sqrt_cell.sv
rtl/core/heron_triangle_area.sv
bench/hta_checker.sv
bench/tb_heron_triangle_area.sv
